FILE: design/pose_to_box_corners_defines.svh
// assertion macros for the pose to box corners block
`ifndef POSE_TO_BOX_CORNERS_DEFINES_SVH
`define POSE_TO_BOX_CORNERS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge out of reset
`define PTBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent on the next edge
`define PTBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTBC_ASSERT(lbl, prop, msg)
`define PTBC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/ptbc_pkg.sv
package ptbc_pkg;

    localparam int CORNER_COUNT = 8;
    localparam int IDX_W        = $clog2(CORNER_COUNT);

    localparam int POS_W     = 32;
    localparam int POS_FRAC  = 16;
    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = 14;
    localparam int HALF_W    = 31;
    localparam int CFG_IDX_W = 2;

    // fixed-point pipeline widths
    localparam int QPROD_W      = 2 * QUAT_W;
    localparam int Q28_FRAC     = 2 * QUAT_FRAC;
    localparam int Q28_W        = QPROD_W + 2;
    localparam int MAT_FRAC     = 24;
    localparam int MAT_SHIFT    = Q28_FRAC - MAT_FRAC;
    localparam int MAT_W        = Q28_W - MAT_SHIFT;
    localparam int SCALED_W     = MAT_W + HALF_W + 1;
    localparam int ACC_W        = 64;
    localparam int CORNER_SHIFT = MAT_FRAC;
    localparam int RND_W        = ACC_W - CORNER_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Z = 2'd2;

    localparam logic [HALF_W-1:0] HALF_X_RESET = 31'd6554;
    localparam logic [HALF_W-1:0] HALF_Y_RESET = 31'd6554;
    localparam logic [HALF_W-1:0] HALF_Z_RESET = 31'd13107;

    typedef logic [2:0][HALF_W-1:0] half_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [QUAT_W-1:0]     qx;
        logic [QUAT_W-1:0]     qy;
        logic [QUAT_W-1:0]     qz;
        logic [QUAT_W-1:0]     qw;
    } pose_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0]      pos;
        logic [2:0][2:0][MAT_W-1:0] m;
    } matrix_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0]         pos;
        logic [2:0][2:0][SCALED_W-1:0] p;
    } scaled_t;

endpackage

FILE: design/ptbc_if.sv
interface ptbc_pose_if;
    logic        valid;
    logic        ready;
    logic [31:0] position_x;
    logic [31:0] position_y;
    logic [31:0] position_z;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;
    logic [15:0] quat_w;

    modport source (
        output valid, position_x, position_y, position_z, quat_x, quat_y, quat_z, quat_w,
        input  ready
    );
    modport sink (
        input  valid, position_x, position_y, position_z, quat_x, quat_y, quat_z, quat_w,
        output ready
    );
endinterface

interface ptbc_corner_if;
    logic        valid;
    logic        ready;
    logic [31:0] corner_x;
    logic [31:0] corner_y;
    logic [31:0] corner_z;
    logic [2:0]  corner_index;
    logic        last_corner;

    modport source (
        output valid, corner_x, corner_y, corner_z, corner_index, last_corner,
        input  ready
    );
    modport sink (
        input  valid, corner_x, corner_y, corner_z, corner_index, last_corner,
        output ready
    );
endinterface

FILE: design/ptbc_matrix.sv
module ptbc_matrix
    import ptbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  pose_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output matrix_t out_data
);

    localparam logic signed [Q28_W:0] ONE_Q28  = (Q28_W + 1)'(64'd1 << Q28_FRAC);
    localparam logic signed [Q28_W:0] HALF_LSB = (Q28_W + 1)'(64'd1 << (MAT_SHIFT - 1));

    // one matrix entry: 2(a +/- b), or one minus that on the diagonal, rounded half up
    function automatic logic [MAT_W-1:0] mat_entry(
        input logic [QPROD_W-1:0] a,
        input logic [QPROD_W-1:0] b,
        input logic               sub_b,
        input logic               diag
    );
        logic signed [Q28_W:0] sa;
        logic signed [Q28_W:0] sb;
        logic signed [Q28_W:0] s;
        logic signed [Q28_W:0] q;
        sa = (Q28_W + 1)'($signed(a));
        sb = (Q28_W + 1)'($signed(b));
        s  = sub_b ? (sa - sb) : (sa + sb);
        q  = diag ? (ONE_Q28 - (s <<< 1)) : (s <<< 1);
        q  = q + HALF_LSB;
        return q[MAT_W+MAT_SHIFT-1:MAT_SHIFT];
    endfunction

    // stage 1: quaternion products
    logic                  s1_valid_reg;
    logic [2:0][POS_W-1:0] s1_pos_reg;
    logic [QPROD_W-1:0]    xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic [QPROD_W-1:0]    wx_reg, wy_reg, wz_reg;
    // stage 2: rounded matrix
    logic                  s2_valid_reg;
    matrix_t               s2_data_reg;

    logic s1_en;
    logic s2_en;

    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_pos_reg <= in_data.pos;
            xx_reg <= QPROD_W'($signed(in_data.qx) * $signed(in_data.qx));
            yy_reg <= QPROD_W'($signed(in_data.qy) * $signed(in_data.qy));
            zz_reg <= QPROD_W'($signed(in_data.qz) * $signed(in_data.qz));
            xy_reg <= QPROD_W'($signed(in_data.qx) * $signed(in_data.qy));
            xz_reg <= QPROD_W'($signed(in_data.qx) * $signed(in_data.qz));
            yz_reg <= QPROD_W'($signed(in_data.qy) * $signed(in_data.qz));
            wx_reg <= QPROD_W'($signed(in_data.qw) * $signed(in_data.qx));
            wy_reg <= QPROD_W'($signed(in_data.qw) * $signed(in_data.qy));
            wz_reg <= QPROD_W'($signed(in_data.qw) * $signed(in_data.qz));
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_data_reg.pos     <= s1_pos_reg;
            s2_data_reg.m[0][0] <= mat_entry(yy_reg, zz_reg, 1'b0, 1'b1);
            s2_data_reg.m[0][1] <= mat_entry(xy_reg, wz_reg, 1'b1, 1'b0);
            s2_data_reg.m[0][2] <= mat_entry(xz_reg, wy_reg, 1'b0, 1'b0);
            s2_data_reg.m[1][0] <= mat_entry(xy_reg, wz_reg, 1'b0, 1'b0);
            s2_data_reg.m[1][1] <= mat_entry(xx_reg, zz_reg, 1'b0, 1'b1);
            s2_data_reg.m[1][2] <= mat_entry(yz_reg, wx_reg, 1'b1, 1'b0);
            s2_data_reg.m[2][0] <= mat_entry(xz_reg, wy_reg, 1'b1, 1'b0);
            s2_data_reg.m[2][1] <= mat_entry(yz_reg, wx_reg, 1'b0, 1'b0);
            s2_data_reg.m[2][2] <= mat_entry(xx_reg, yy_reg, 1'b0, 1'b1);
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

FILE: design/ptbc_scale.sv
module ptbc_scale
    import ptbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  half_t   half,
    input  logic    in_valid,
    output logic    in_ready,
    input  matrix_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output scaled_t out_data
);

    logic    valid_reg;
    scaled_t data_reg;
    logic    en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // each column scaled by its half extent
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg.pos <= in_data.pos;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    data_reg.p[i][j] <= SCALED_W'($signed(in_data.m[i][j])
                                                  * $signed({1'b0, half[j]}));
                end
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/ptbc_corner.sv
module ptbc_corner
    import ptbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  scaled_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0][POS_W-1:0] out_corner,
    output logic [IDX_W-1:0]      out_index,
    output logic                  out_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORNER_COUNT - 1);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (CORNER_SHIFT - 1));

    // pose held while its corners are walked
    logic             seq_valid_reg;
    scaled_t          seq_data_reg;
    logic [IDX_W-1:0] cnt_reg;

    // rounded rotated offsets
    logic                  c1_valid_reg;
    logic [2:0][RND_W-1:0] c1_rnd_reg;
    logic [2:0][POS_W-1:0] c1_pos_reg;
    logic [IDX_W-1:0]      c1_index_reg;
    logic                  c1_last_reg;

    // output register
    logic                  o_valid_reg;
    logic [2:0][POS_W-1:0] o_corner_reg;
    logic [IDX_W-1:0]      o_index_reg;
    logic                  o_last_reg;

    logic o_en;
    logic c1_en;
    logic seq_fire;
    logic in_fire;

    logic signed [ACC_W-1:0]   acc [3];
    logic [2:0][RND_W-1:0]     rnd;
    logic signed [RND_W-1:0]   sum [3];
    logic [2:0][POS_W-1:0]     sat;

    assign o_en     = !o_valid_reg || out_ready;
    assign c1_en    = !c1_valid_reg || o_en;
    assign seq_fire = seq_valid_reg && c1_en;
    assign in_ready = !seq_valid_reg || (seq_fire && (cnt_reg == LAST_IDX));
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = HALF_LSB;
            for (int j = 0; j < 3; j++)
            begin
                if (cnt_reg[2-j])
                    acc[i] = acc[i] + ACC_W'($signed(seq_data_reg.p[i][j]));
                else
                    acc[i] = acc[i] - ACC_W'($signed(seq_data_reg.p[i][j]));
            end
            rnd[i] = acc[i][ACC_W-1:CORNER_SHIFT];
        end
    end

    // add position, clamp to the signed 32-bit range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = $signed(c1_rnd_reg[i]) + RND_W'($signed(c1_pos_reg[i]));
            if (sum[i][RND_W-1:POS_W-1] == '0 || sum[i][RND_W-1:POS_W-1] == '1)
                sat[i] = sum[i][POS_W-1:0];
            else if (sum[i][RND_W-1])
                sat[i] = {1'b1, {(POS_W-1){1'b0}}};
            else
                sat[i] = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            c1_valid_reg  <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                seq_valid_reg <= 1'b1;
                cnt_reg       <= '0;
            end
            else if (seq_fire)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                    seq_valid_reg <= 1'b0;
            end
            if (c1_en)
                c1_valid_reg <= seq_valid_reg;
            if (o_en)
                o_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            seq_data_reg <= in_data;
        if (seq_fire)
        begin
            c1_rnd_reg   <= rnd;
            c1_pos_reg   <= seq_data_reg.pos;
            c1_index_reg <= cnt_reg;
            c1_last_reg  <= (cnt_reg == LAST_IDX);
        end
        if (o_en && c1_valid_reg)
        begin
            o_corner_reg <= sat;
            o_index_reg  <= c1_index_reg;
            o_last_reg   <= c1_last_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_corner = o_corner_reg;
    assign out_index  = o_index_reg;
    assign out_last   = o_last_reg;

endmodule

FILE: design/pose_to_box_corners.sv
// pose to oriented box corners
//
// pose channel (sink): one rigid-body pose per request, position in signed
// Q16.16 and an unnormalized quaternion in signed Q2.14.
// corner channel (source): eight corner requests per pose, corner_index
// counting 0 to 7 (bit2 x sign, bit1 y sign, bit0 z sign, 1 = plus), with
// last_corner set on index 7. corners are saturated to signed 32 bits.
// config port: cfg_we / cfg_index / cfg_data set the three half extents
// (unsigned Q15.16); index 3 is ignored. write only while the block is idle.
//
// path: an accepted pose passes the product, matrix, scale and walker
// registers, then the rounded-offset and output registers of the walker.
// throughput: one corner per cycle while corner.ready is high; the
// corner walker holds a pose until all eight of its corners have left it.
// the next pose is accepted on the cycle the last corner of the current
// one leaves the walker, with no gap between poses.
// reset: all stages empty, half extents back to 0.1 / 0.1 / 0.2.
// stall: while corner.ready is low the output holds its request and the
// stages behind it fill up in turn; nothing is dropped or repeated.
`include "pose_to_box_corners_defines.svh"

module pose_to_box_corners
    import ptbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ptbc_pose_if.sink            pose,
    ptbc_corner_if.source        corner,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data
);

    // half extent registers
    logic [HALF_W-1:0] half_x_reg;
    logic [HALF_W-1:0] half_y_reg;
    logic [HALF_W-1:0] half_z_reg;
    half_t             half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= HALF_X_RESET;
            half_y_reg <= HALF_Y_RESET;
            half_z_reg <= HALF_Z_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_X: half_x_reg <= cfg_data;
                REG_HALF_Y: half_y_reg <= cfg_data;
                REG_HALF_Z: half_z_reg <= cfg_data;
                default:    ;  // no register at this index
            endcase
        end
    end

    assign half[0] = half_x_reg;
    assign half[1] = half_y_reg;
    assign half[2] = half_z_reg;

    // incoming pose request packed for the pipeline
    pose_t pose_data;

    assign pose_data.pos[0] = pose.position_x;
    assign pose_data.pos[1] = pose.position_y;
    assign pose_data.pos[2] = pose.position_z;
    assign pose_data.qx     = pose.quat_x;
    assign pose_data.qy     = pose.quat_y;
    assign pose_data.qz     = pose.quat_z;
    assign pose_data.qw     = pose.quat_w;

    // quaternion products, then the rounded rotation matrix (2 stages)
    logic    mat_valid;
    logic    mat_ready;
    matrix_t mat_data;

    ptbc_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pose.valid),
        .in_ready  (pose.ready),
        .in_data   (pose_data),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_data  (mat_data)
    );

    // matrix columns times the half extents (1 stage)
    logic    scl_valid;
    logic    scl_ready;
    scaled_t scl_data;

    ptbc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .half      (half),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_data   (mat_data),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    // corner walker: signed sums and rounding, then position add and clamp
    logic [2:0][POS_W-1:0] corner_xyz;

    ptbc_corner u_corner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (scl_valid),
        .in_ready   (scl_ready),
        .in_data    (scl_data),
        .out_valid  (corner.valid),
        .out_ready  (corner.ready),
        .out_corner (corner_xyz),
        .out_index  (corner.corner_index),
        .out_last   (corner.last_corner)
    );

    assign corner.corner_x = corner_xyz[0];
    assign corner.corner_y = corner_xyz[1];
    assign corner.corner_z = corner_xyz[2];

    // last flag marks exactly the eighth corner
    `PTBC_ASSERT(a_last_on_final,
        !corner.valid || (corner.last_corner == (corner.corner_index == IDX_W'(CORNER_COUNT - 1))),
        "last_corner does not match corner_index")

    // corners of one pose follow back to back in index order
    `PTBC_ASSERT_NEXT(a_corner_seq,
        corner.valid && corner.ready && !corner.last_corner,
        corner.valid && (corner.corner_index == IDX_W'($past(corner.corner_index) + 1'b1)),
        "corner sequence broken inside a pose")

    // a new burst of corners always starts at index zero
    `PTBC_ASSERT(a_burst_start,
        !$rose(corner.valid) || (corner.corner_index == '0),
        "corner burst does not start at index zero")

endmodule
